FILE: design/mafh_pkg.sv
// Shared types, codes and rate tables for the MPEG audio frame header checker.
package mafh_pkg;

  localparam logic [10:0] SYNC_WORD = 11'h7ff;

  // Version codes as reported
  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  // Layer codes as reported
  localparam logic [1:0] LAYER_I   = 2'd0;
  localparam logic [1:0] LAYER_II  = 2'd1;
  localparam logic [1:0] LAYER_III = 2'd2;

  localparam logic [1:0] CH_MODE_SINGLE = 2'd3;
  localparam logic [1:0] EMPH_FORBIDDEN = 2'd2;
  localparam logic [1:0] SRI_RESERVED   = 2'd3;
  localparam logic [3:0] BRI_FREE       = 4'd0;
  localparam logic [3:0] BRI_BAD        = 4'd15;

  localparam int NUM_W = 26;  // base * bitrate, below 2^26 for every good header
  localparam int DEN_W = 16;  // sample rate in Hz
  localparam int QUO_W = 11;  // frame size before padding
  localparam int CNT_W = $clog2(NUM_W);

  // Bitrates in kbit/s, indexed by bitrate index
  localparam logic [8:0] BR_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] BR_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] BR_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BR_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] BR_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Frame size base times 1000, so it pairs with kbit/s
  localparam logic [17:0] BASE_L1_K = 18'd12000;
  localparam logic [17:0] BASE_V1_K = 18'd144000;
  localparam logic [17:0] BASE_V2_K = 18'd72000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       set;
    logic [1:0] ver;
    logic [1:0] lay;
    logic [1:0] rate;
    logic [1:0] mode;
  } lock_t;

  typedef struct packed {
    logic             ok;
    logic [1:0]       ver;
    logic [1:0]       lay;
    logic             crc;
    logic [3:0]       bri;
    logic [1:0]       sri;
    logic             pad;
    logic [1:0]       mode;
    logic [1:0]       mext;
    logic [1:0]       ch;
    logic [5:0]       side;
    logic             mult4;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } dec_t;

  function automatic logic [8:0] bitrate_kbps(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] bri);
    logic [8:0] r;
    r = '0;
    if (ver == VER_MPEG1) begin
      unique case (lay)
        LAYER_I:   r = BR_V1_L1[bri];
        LAYER_II:  r = BR_V1_L2[bri];
        LAYER_III: r = BR_V1_L3[bri];
        default:   r = '0;
      endcase
    end else begin
      r = (lay == LAYER_I) ? BR_V2_L1[bri] : BR_V2_L23[bri];
    end
    return r;
  endfunction

  function automatic logic [DEN_W-1:0] sample_rate(input logic [1:0] ver,
                                                   input logic [1:0] sri);
    logic [DEN_W-1:0] r;
    unique case (sri)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = 16'd1;
    endcase
    unique case (ver)
      VER_MPEG2:  r = r >> 1;
      VER_MPEG25: r = r >> 2;
      default:    r = r;
    endcase
    return r;
  endfunction

endpackage

FILE: design/mafh_decode.sv
// Header field split, validity and lock checks, and divider operands.
module mafh_decode import mafh_pkg::*; (
  input  logic [31:0] header_i,
  input  lock_t       lock_i,
  output dec_t        dec_o
);

  logic [1:0]  vbits, lbits, emph;
  logic        ok_fmt, ok_ver, ok_lay;
  logic [8:0]  kbps;
  logic [17:0] base_k;
  logic [26:0] prod;

  assign vbits = header_i[20:19];
  assign lbits = header_i[18:17];
  assign emph  = header_i[1:0];

  always_comb begin
    dec_o      = '0;
    ok_ver     = 1'b1;
    ok_lay     = 1'b1;
    unique case (vbits)
      2'd3:    dec_o.ver = VER_MPEG1;
      2'd2:    dec_o.ver = VER_MPEG2;
      2'd0:    dec_o.ver = VER_MPEG25;
      default: ok_ver = 1'b0;
    endcase
    unique case (lbits)
      2'd3:    dec_o.lay = LAYER_I;
      2'd2:    dec_o.lay = LAYER_II;
      2'd1:    dec_o.lay = LAYER_III;
      default: ok_lay = 1'b0;
    endcase
    dec_o.crc  = ~header_i[16];
    dec_o.bri  = header_i[15:12];
    dec_o.sri  = header_i[11:10];
    dec_o.pad  = header_i[9];
    dec_o.mode = header_i[7:6];
    dec_o.mext = header_i[5:4];

    ok_fmt = (header_i[31:21] == SYNC_WORD) && ok_ver && ok_lay &&
             (dec_o.bri != BRI_FREE) && (dec_o.bri != BRI_BAD) &&
             (dec_o.sri != SRI_RESERVED) && (emph != EMPH_FORBIDDEN);
    dec_o.ok = ok_fmt && (!lock_i.set ||
               ((dec_o.ver == lock_i.ver) && (dec_o.lay == lock_i.lay) &&
                (dec_o.sri == lock_i.rate) && (dec_o.mode == lock_i.mode)));

    dec_o.ch = (dec_o.mode == CH_MODE_SINGLE) ? 2'd1 : 2'd2;
    if (dec_o.lay == LAYER_III) begin
      if (dec_o.ver == VER_MPEG1) dec_o.side = (dec_o.mode == CH_MODE_SINGLE) ? 6'd17 : 6'd32;
      else                        dec_o.side = (dec_o.mode == CH_MODE_SINGLE) ? 6'd9 : 6'd17;
    end
    dec_o.mult4 = (dec_o.lay == LAYER_I);

    kbps = bitrate_kbps(dec_o.ver, dec_o.lay, dec_o.bri);
    if (dec_o.lay == LAYER_I)           base_k = BASE_L1_K;
    else if (dec_o.ver == VER_MPEG1)    base_k = BASE_V1_K;
    else                                base_k = BASE_V2_K;
    prod      = kbps * base_k;
    dec_o.num = prod[NUM_W-1:0];
    dec_o.den = sample_rate(dec_o.ver, dec_o.sri);
  end

endmodule

FILE: design/mafh_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module mafh_div import mafh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [DEN_W:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_q, acc_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // quotient bits shift in behind the dividend
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sub[DEN_W-1:0];
        acc_d = {acc_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        acc_d = {acc_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = acc_q[QUO_W-1:0];

endmodule

FILE: design/mpeg_audio_frame_header_check.sv
// Top level: MPEG audio frame header checker with stream lock and payload size.
//
//  Channel | Direction | Handshake               | Payload
//  in      | input     | in_valid_i / in_ready_o | header_word_i, clear_lock_i
//  out     | output    | out_valid_o/out_ready_i | valid_res_o ... payload_bytes_o
//
// A good header goes from accept to result through decode, the bit-serial divider
// for floor(base*bitrate/samplerate) (26 steps, then done), and a final step
// that finishes the size. A rejected header skips the divider.
// One item at a time; in_ready_o is high only when the sequencer is idle.
// The result sits in an output register; a stalled output holds the sequencer
// in its last state until the register frees up.
// Reset clears the lock and all control state; no clearing pass.
module mpeg_audio_frame_header_check import mafh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] header_word_i,
  input  logic        clear_lock_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [1:0]  version_o,
  output logic [1:0]  layer_index_o,
  output logic        crc_present_o,
  output logic [3:0]  bitrate_index_o,
  output logic [1:0]  rate_index_o,
  output logic        padding_o,
  output logic [1:0]  channel_mode_o,
  output logic [1:0]  mode_ext_o,
  output logic [1:0]  channels_o,
  output logic [5:0]  side_info_bytes_o,
  output logic [10:0] payload_bytes_o
);

  state_e      state_q, state_d;
  lock_t       lock_q, lock_d;
  logic [31:0] header_q;
  dec_t        dec, dec_q;
  logic        out_valid_q, out_valid_d;
  dec_t        res_q, res_d;
  logic [10:0] pay_q, pay_d;

  logic             div_start, div_busy, div_done;
  logic [QUO_W-1:0] quo;
  logic             in_acc, out_load;
  logic signed [13:0] fsize, total;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  mafh_decode u_decode (
    .header_i (header_q),
    .lock_i   (lock_q),
    .dec_o    (dec)
  );

  mafh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dec.num),
    .den_i   (dec.den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // size from quotient and padding (x4 for layer I), less header, CRC and side info
  always_comb begin
    fsize = 14'(quo) + 14'(dec_q.pad);
    if (dec_q.mult4) fsize = fsize <<< 2;
    total = fsize - 14'sd4 - (dec_q.crc ? 14'sd2 : 14'sd0) - 14'(dec_q.side);
  end

  always_comb begin
    state_d     = state_q;
    lock_d      = lock_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    res_d       = res_q;
    pay_d       = pay_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (clear_lock_i) lock_d.set = 1'b0;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (dec.ok) begin
          lock_d.set  = 1'b1;
          lock_d.ver  = dec.ver;
          lock_d.lay  = dec.lay;
          lock_d.rate = dec.sri;
          lock_d.mode = dec.mode;
          div_start   = 1'b1;
          state_d     = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (dec_q.ok) begin
            res_d = dec_q;
            priority if (total < 0)         pay_d = '0;
            else if (total > 14'sd2047)     pay_d = 11'd2047;
            else                            pay_d = total[10:0];
          end else begin
            res_d = '0;
            pay_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lock_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lock_q      <= lock_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) header_q <= header_word_i;
    if (state_q == ST_DECODE) dec_q <= dec;
    res_q <= res_d;
    pay_q <= pay_d;
  end

  assign out_valid_o       = out_valid_q;
  assign valid_res_o       = res_q.ok;
  assign version_o         = res_q.ver;
  assign layer_index_o     = res_q.lay;
  assign crc_present_o     = res_q.crc;
  assign bitrate_index_o   = res_q.bri;
  assign rate_index_o      = res_q.sri;
  assign padding_o         = res_q.pad;
  assign channel_mode_o    = res_q.mode;
  assign mode_ext_o        = res_q.mext;
  assign channels_o        = res_q.ch;
  assign side_info_bytes_o = res_q.side;
  assign payload_bytes_o   = pay_q;

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (payload_bytes_o == 11'd0 && channels_o == 2'd0))
    else $error("rejected header carries nonzero fields");

  a_good_has_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && valid_res_o |-> lock_q.set)
    else $error("accepted header left no lock");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before delivery");

endmodule

FILE: verif/mpeg_audio_frame_header_check_test.sv
`timescale 1ns / 100ps
// Testbench for the MPEG audio frame header checker: directed rows, then random headers.
module mpeg_audio_frame_header_check_test;
  import mafh_pkg::*;

  localparam int NUM_RANDOM  = 1430;
  localparam int QUIET_TAIL  = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  // Raw header codes for version and layer
  localparam logic [1:0] VB_MPEG1    = 2'b11;
  localparam logic [1:0] VB_MPEG2    = 2'b10;
  localparam logic [1:0] VB_MPEG25   = 2'b00;
  localparam logic [1:0] VB_RESERVED = 2'b01;
  localparam logic [1:0] LB_I        = 2'b11;
  localparam logic [1:0] LB_II       = 2'b10;
  localparam logic [1:0] LB_III      = 2'b01;
  localparam logic [1:0] LB_RESERVED = 2'b00;

  // kbit/s; rows: V1 L1, V1 L2, V1 L3, V2 L1, V2 L2, V2 L3
  localparam int unsigned KBPS_TAB [96] = '{
    0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0,
    0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0,
    0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0,
    0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0,
    0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0,
    0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
  localparam int unsigned SAMPLE_HZ [9] = '{44100, 48000, 32000, 22050, 24000, 16000,
                                            11025, 12000, 8000};

  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        crc;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic        pad;
    logic [1:0]  mode;
    logic [1:0]  mext;
    logic [1:0]  ch;
    logic [5:0]  side;
    logic [10:0] payload;
  } hdr_res_t;

  typedef struct {
    logic [31:0] hw;
    logic        clr;
    bit          typed;
    hdr_res_t    res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] header_word_i = '0;
  logic        clear_lock_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        valid_res_o;
  logic [1:0]  version_o;
  logic [1:0]  layer_index_o;
  logic        crc_present_o;
  logic [3:0]  bitrate_index_o;
  logic [1:0]  rate_index_o;
  logic        padding_o;
  logic [1:0]  channel_mode_o;
  logic [1:0]  mode_ext_o;
  logic [1:0]  channels_o;
  logic [5:0]  side_info_bytes_o;
  logic [10:0] payload_bytes_o;

  // Stream lock as the testbench sees it
  logic       lock_held = 1'b0;
  logic [1:0] lock_ver  = '0;
  logic [1:0] lock_lay  = '0;
  logic [1:0] lock_sri  = '0;
  logic [1:0] lock_mode = '0;

  hdr_res_t  pending_results [$];
  stim_row_t stim_rows [$];
  int        mismatch_count = 0;
  int        stuck_cycles = 0;
  bit        idle_enable = 1'b1;
  bit        quiet = 1'b0;

  mpeg_audio_frame_header_check u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .header_word_i     (header_word_i),
    .clear_lock_i      (clear_lock_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .valid_res_o       (valid_res_o),
    .version_o         (version_o),
    .layer_index_o     (layer_index_o),
    .crc_present_o     (crc_present_o),
    .bitrate_index_o   (bitrate_index_o),
    .rate_index_o      (rate_index_o),
    .padding_o         (padding_o),
    .channel_mode_o    (channel_mode_o),
    .mode_ext_o        (mode_ext_o),
    .channels_o        (channels_o),
    .side_info_bytes_o (side_info_bytes_o),
    .payload_bytes_o   (payload_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Checks one header against the lock, updates the lock, returns the decoded fields
  function automatic hdr_res_t predict_header(input logic [31:0] hw, input logic clr);
    hdr_res_t    r;
    logic        ok;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        mono;
    int unsigned kbps;
    int unsigned hz;
    int unsigned base;
    int unsigned mult;
    int unsigned fsize;
    int          payload;
    r   = '0;
    ok  = 1'b1;
    ver = VER_MPEG1;
    lay = LAYER_I;
    if (clr) lock_held = 1'b0;
    if (hw[31:21] != SYNC_WORD) ok = 1'b0;
    case (hw[20:19])
      VB_MPEG1:  ver = VER_MPEG1;
      VB_MPEG2:  ver = VER_MPEG2;
      VB_MPEG25: ver = VER_MPEG25;
      default:   ok = 1'b0;
    endcase
    case (hw[18:17])
      LB_I:    lay = LAYER_I;
      LB_II:   lay = LAYER_II;
      LB_III:  lay = LAYER_III;
      default: ok = 1'b0;
    endcase
    if (hw[15:12] == BRI_FREE || hw[15:12] == BRI_BAD) ok = 1'b0;
    if (hw[11:10] == SRI_RESERVED) ok = 1'b0;
    if (hw[1:0] == EMPH_FORBIDDEN) ok = 1'b0;
    if (ok && lock_held && (ver != lock_ver || lay != lock_lay ||
                            hw[11:10] != lock_sri || hw[7:6] != lock_mode))
      ok = 1'b0;
    if (!ok) return r;

    lock_held = 1'b1;
    lock_ver  = ver;
    lock_lay  = lay;
    lock_sri  = hw[11:10];
    lock_mode = hw[7:6];

    mono   = (hw[7:6] == CH_MODE_SINGLE);
    r.ok   = 1'b1;
    r.ver  = ver;
    r.lay  = lay;
    r.crc  = ~hw[16];
    r.bri  = hw[15:12];
    r.sri  = hw[11:10];
    r.pad  = hw[9];
    r.mode = hw[7:6];
    r.mext = hw[5:4];
    r.ch   = mono ? 2'd1 : 2'd2;
    if (lay == LAYER_III)
      r.side = (ver == VER_MPEG1) ? (mono ? 6'd17 : 6'd32) : (mono ? 6'd9 : 6'd17);

    kbps  = KBPS_TAB[((ver == VER_MPEG1) ? 0 : 48) + 16 * lay + hw[15:12]];
    hz    = SAMPLE_HZ[3 * ver + hw[11:10]];
    base  = (lay == LAYER_I) ? 12 : (ver == VER_MPEG1) ? 144 : 72;
    mult  = (lay == LAYER_I) ? 4 : 1;
    fsize = ((base * kbps * 1000) / hz + hw[9]) * mult;
    payload = int'(fsize) - 4 - (r.crc ? 2 : 0) - int'(r.side);
    if (payload < 0) payload = 0;
    if (payload > 2047) payload = 2047;
    r.payload = payload[10:0];
    return r;
  endfunction

  task automatic add_row(input logic [31:0] hw, input logic clr, input bit typed,
                         input hdr_res_t res);
    stim_row_t row;
    row.hw    = hw;
    row.clr   = clr;
    row.typed = typed;
    row.res   = res;
    stim_rows.push_back(row);
  endtask

  // Mostly headers that fit the current lock; some relocks, broken fields and noise
  task automatic make_random_item(output logic [31:0] hw, output logic clr);
    int unsigned pick;
    int unsigned e;
    logic [31:0] rnd;
    logic [10:0] sync_flip;
    logic [3:0]  bri;
    logic [1:0]  vb;
    logic [1:0]  lb;
    logic [1:0]  sri;
    logic [1:0]  mode;
    logic [1:0]  emph;
    pick = $urandom_range(0, 99);
    rnd  = $urandom;
    bri  = 4'($urandom_range(1, 14));
    e    = $urandom_range(0, 2);
    emph = (e == 2) ? 2'd3 : e[1:0];
    if (lock_held && pick < 70) begin
      vb   = (lock_ver == VER_MPEG1) ? VB_MPEG1 : (lock_ver == VER_MPEG2) ? VB_MPEG2 : VB_MPEG25;
      lb   = (lock_lay == LAYER_I) ? LB_I : (lock_lay == LAYER_II) ? LB_II : LB_III;
      sri  = lock_sri;
      mode = lock_mode;
    end else begin
      e    = $urandom_range(0, 2);
      vb   = (e == 0) ? VB_MPEG1 : (e == 1) ? VB_MPEG2 : VB_MPEG25;
      e    = $urandom_range(0, 2);
      lb   = (e == 0) ? LB_I : (e == 1) ? LB_II : LB_III;
      sri  = 2'($urandom_range(0, 2));
      mode = 2'($urandom_range(0, 3));
    end
    hw  = {SYNC_WORD, vb, lb, rnd[0], bri, sri, rnd[1], rnd[2], mode, rnd[6:5],
           rnd[3], rnd[4], emph};
    clr = (pick >= 70 && pick < 76) || ($urandom_range(0, 49) == 0);
    if (pick >= 82 && pick < 92) begin
      sync_flip = 11'($urandom_range(1, 2047));
      case ($urandom_range(0, 5))
        0:       hw[31:21] = SYNC_WORD ^ sync_flip;
        1:       hw[20:19] = VB_RESERVED;
        2:       hw[18:17] = LB_RESERVED;
        3:       hw[15:12] = rnd[7] ? BRI_BAD : BRI_FREE;
        4:       hw[11:10] = SRI_RESERVED;
        default: hw[1:0]   = EMPH_FORBIDDEN;
      endcase
    end else if (pick >= 92) begin
      hw  = $urandom;
      clr = rnd[8];
    end
  endtask

  // Called just after the clock rises; returns when the design accepts the item
  task automatic send_item(input logic [31:0] hw, input logic clr, input bit typed,
                           input hdr_res_t typed_res);
    hdr_res_t predicted;
    if (idle_enable && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    header_word_i <= hw;
    clear_lock_i  <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_header(hw, clr);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    hdr_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("valid_res", want.ok, valid_res_o);
        check_field("version", want.ver, version_o);
        check_field("layer_index", want.lay, layer_index_o);
        check_field("crc_present", want.crc, crc_present_o);
        check_field("bitrate_index", want.bri, bitrate_index_o);
        check_field("rate_index", want.sri, rate_index_o);
        check_field("padding", want.pad, padding_o);
        check_field("channel_mode", want.mode, channel_mode_o);
        check_field("mode_ext", want.mext, mode_ext_o);
        check_field("channels", want.ch, channels_o);
        check_field("side_info_bytes", want.side, side_info_bytes_o);
        check_field("payload_bytes", want.payload, payload_bytes_o);
      end
    end
  end

  // Stretches with and without idling
  initial begin
    forever begin
      idle_enable <= ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(100, 600)) @(posedge clk_i);
    end
  end

  // Output back-pressure in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_enable && !quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] hw;
    logic        clr;
    // after reset: lock empty
    add_row(32'h0000_0000, 1'b0, 1'b1, '0);
    add_row(32'hFFFF_FFFF, 1'b0, 1'b1, '0);
    // first good header sets the lock: MPEG1 layer III, 128k, 44.1k, stereo
    add_row(32'hFFFB_9000, 1'b0, 1'b1, '{1'b1, VER_MPEG1, LAYER_III, 1'b0, 4'd9, 2'd0,
                                         1'b0, 2'd0, 2'd0, 2'd2, 6'd32, 11'd381});
    // each reject reason in turn
    add_row(32'hFFDB_9000, 1'b0, 1'b1, '0);  // broken sync
    add_row(32'hFFEB_9000, 1'b0, 1'b1, '0);  // reserved version
    add_row(32'hFFF9_9000, 1'b0, 1'b1, '0);  // reserved layer
    add_row(32'hFFFB_0000, 1'b0, 1'b1, '0);  // free format
    add_row(32'hFFFB_F000, 1'b0, 1'b1, '0);  // bad bitrate
    add_row(32'hFFFB_9C00, 1'b0, 1'b1, '0);  // reserved sample rate
    add_row(32'hFFFB_9002, 1'b0, 1'b1, '0);  // reserved emphasis
    // well-formed but against the lock
    add_row(32'hFFF3_9000, 1'b0, 1'b1, '0);
    add_row(32'hFFFD_9000, 1'b0, 1'b1, '0);
    add_row(32'hFFFB_9400, 1'b0, 1'b1, '0);
    add_row(32'hFFFB_90C0, 1'b0, 1'b1, '0);
    // matches lock; CRC, padding and ignored bits set
    add_row(32'hFFFA_933F, 1'b0, 1'b0, '0);
    // largest payload, relock in the same item
    add_row(32'hFFFD_EA00, 1'b1, 1'b1, '{1'b1, VER_MPEG1, LAYER_II, 1'b0, 4'd14, 2'd2,
                                         1'b1, 2'd0, 2'd0, 2'd2, 6'd0, 11'd1725});
    // reject with clear still drops the lock
    add_row(32'h0000_0000, 1'b1, 1'b1, '0);
    add_row(32'hFFF2_18C0, 1'b0, 1'b0, '0);
    add_row(32'hFFE7_E160, 1'b1, 1'b0, '0);
    add_row(32'hFFFB_18C0, 1'b1, 1'b0, '0);
    add_row(32'hFFFF_1400, 1'b1, 1'b0, '0);
    add_row(32'hFFF5_E880, 1'b1, 1'b0, '0);
    add_row(32'hFFE2_1840, 1'b1, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i])
      send_item(stim_rows[i].hw, stim_rows[i].clr, stim_rows[i].typed, stim_rows[i].res);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n >= NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      make_random_item(hw, clr);
      send_item(hw, clr, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
design/mafh_pkg.sv
design/mafh_decode.sv
design/mafh_div.sv
design/mpeg_audio_frame_header_check.sv
verif/mpeg_audio_frame_header_check_test.sv
